>>> src/cbd_pkg.sv
// Shared types, constants and calendar tables for the days-between-dates block.
`default_nettype none

package cbd_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int CountW = 22;

  localparam logic [YearW-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MonthW-1:0] MONTH_MAX = 4'd12;
  localparam logic [CountW-1:0] COUNT_MAX = 22'd3652058;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_FIRST  = 2'd1;
  localparam logic [1:0] ST_BAD_SECOND = 2'd2;
  localparam logic [1:0] ST_REVERSED   = 2'd3;

  // Reciprocals of 25, exact for the ranges they are used on
  localparam logic [10:0] RECIP25_WIDE = 11'd1311;  // x < 4096, shift 15
  localparam logic [5:0]  RECIP25_NARROW = 6'd41;   // x < 1024, shift 10

  localparam logic [8:0]  DAYS_400Y_LO = 9'd400;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

  typedef struct packed {
    logic [YearW-1:0]  start_year;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic [YearW-1:0]  end_year;
    logic [MonthW-1:0] end_month;
    logic [DayW-1:0]   end_day;
  } dates_t;

  typedef struct packed {
    logic [CountW-1:0] day_count;
    logic [1:0]        status;
  } result_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    logic              ok;
    logic [CountW-1:0] num;
  } daynum_t;

  // Days from March 1 to the first of the month (year counted from March)
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] r;
    case (m) inside
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/calendar_days_between_dates.sv
// Top level: days between two Gregorian dates, pipelined, with an output skid stage.
`default_nettype none

// Takes a word holding two proleptic Gregorian dates (year, month, day each) and
// returns the number of days from the first to the second, with the status code
// ST_OK, ST_BAD_FIRST (first date invalid; checked first), ST_BAD_SECOND or
// ST_REVERSED (second date before the first); day_count is 0 unless status is
// ST_OK. A date is valid for years 1 to 9999, months 1 to 12 and days 1 to the
// month length under the leap-year rule. Rate: one word per cycle while the skid
// stage is empty. Each word passes the four day-number stages, then the compare
// and subtract into the output register. Both dates run through their own copy of
// the day-number pipeline; all constant divisions are done by reciprocal multiplies.
// dates_ready is low during reset and while the skid stage holds a word, which
// happens after result_ready has been low with a result waiting.
module calendar_days_between_dates (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             dates_valid,
  output logic                  dates_ready,
  input  wire cbd_pkg::dates_t  dates,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output cbd_pkg::result_t      result
);
  import cbd_pkg::*;

  localparam int Stages = 4;

  logic             adv;
  logic [Stages:1]  v;
  daynum_t          dn_a, dn_b;
  date_t            date_a, date_b;
  result_t          fin;
  result_t          skid;
  logic             skid_valid;
  logic             out_free;

  // Advance the whole pipeline whenever the skid stage is empty
  assign adv         = !skid_valid;
  assign dates_ready = adv && !rst;

  assign date_a = '{year: dates.start_year, month: dates.start_month, day: dates.start_day};
  assign date_b = '{year: dates.end_year, month: dates.end_month, day: dates.end_day};

  cbd_daynum u_first (
    .clk  (clk),
    .en   (adv),
    .date (date_a),
    .dn   (dn_a)
  );

  cbd_daynum u_second (
    .clk  (clk),
    .en   (adv),
    .date (date_b),
    .dn   (dn_b)
  );

  // Valid bits travel alongside the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[Stages-1:1], dates_valid};
    end
  end

  // Final stage: classify and subtract
  always_comb begin
    fin.day_count = '0;
    if (!dn_a.ok) begin
      fin.status = ST_BAD_FIRST;
    end else if (!dn_b.ok) begin
      fin.status = ST_BAD_SECOND;
    end else if (dn_b.num < dn_a.num) begin
      fin.status = ST_REVERSED;
    end else begin
      fin.status    = ST_OK;
      fin.day_count = dn_b.num - dn_a.num;
    end
  end

  assign out_free = !result_valid || result_ready;

  // Output register with a skid stage behind it: drain the skid first,
  // park a finished word in the skid when the output is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        result       <= skid;
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (v[Stages]) begin
      if (out_free) begin
        result       <= fin;
        result_valid <= 1'b1;
      end else begin
        skid       <= fin;
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid stage holds a word while the output register is empty");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v))
    else $error("pipeline valid bits moved while stalled");

  a_zero_when_bad: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_OK) |-> result.day_count == '0)
    else $error("nonzero day count with a failing status");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_OK) |-> result.day_count <= COUNT_MAX)
    else $error("day count beyond the calendar span");
`endif

endmodule

`default_nettype wire

>>> src/cbd_daynum.sv
// Four-stage pipeline that checks one date and turns it into a day number.
`default_nettype none

module cbd_daynum (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire cbd_pkg::date_t date,
  output cbd_pkg::daynum_t    dn
);
  import cbd_pkg::*;

  // Stage 1: century and era quotients, March-based year, month offset
  logic [YearW-1:0] y1, yy1;
  logic [MonthW-1:0] m1;
  logic [DayW-1:0]   d1;
  logic [7:0]        c1;
  logic [5:0]        era1;
  logic [8:0]        doy1;
  logic              rok1;

  logic [YearW-1:0] yy_c;
  logic [22:0]      cprod;
  logic [15:0]      eprod;

  always_comb begin
    yy_c  = (date.month <= 4'd2) ? date.year - 14'd1 : date.year;
    cprod = 23'(date.year[13:2]) * 23'(RECIP25_WIDE);
    eprod = 16'(yy_c[13:4]) * 16'(RECIP25_NARROW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1   <= date.year;
      yy1  <= yy_c;
      m1   <= date.month;
      d1   <= date.day;
      c1   <= cprod[22:15];
      era1 <= eprod[15:10];
      doy1 <= month_offset(date.month) + 9'(date.day) - 9'd1;
      rok1 <= (date.year != '0) && (date.year <= YEAR_MAX) &&
              (date.month != '0) && (date.month <= MONTH_MAX);
    end
  end

  // Stage 2: leap rule, day range check, year of era
  logic [8:0] yoe2, doy2;
  logic [5:0] era2;
  logic       ok2;

  logic [14:0] c100;
  logic [14:0] e400;
  logic        leap;

  always_comb begin
    c100 = 15'(c1) * 15'(7'd100);
    e400 = 15'(era1) * 15'(DAYS_400Y_LO);
    leap = ((y1[1:0] == 2'd0) && (c100 != 15'(y1))) ||
           ((c100 == 15'(y1)) && (c1[1:0] == 2'd0));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yoe2 <= 9'(15'(yy1) - e400);
      era2 <= era1;
      doy2 <= doy1;
      ok2  <= rok1 && (d1 != '0) && (d1 <= month_days(m1, leap));
    end
  end

  // Stage 3: day of era and era base, computed side by side
  logic [17:0] doe3;
  logic [21:0] ep3;
  logic        ok3;

  logic [12:0] qprod;
  logic [22:0] eraprod;

  always_comb begin
    qprod   = 13'(yoe2[8:2]) * 13'(RECIP25_NARROW);
    eraprod = 23'(era2) * 23'(DAYS_PER_ERA);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      doe3 <= 18'(yoe2) * 18'(DAYS_PER_YEAR) + 18'(yoe2[8:2]) -
              18'(qprod[12:10]) + 18'(doy2);
      ep3  <= eraprod[21:0];
      ok3  <= ok2;
    end
  end

  // Stage 4: day number
  always_ff @(posedge clk) begin
    if (en) begin
      dn.num <= ep3 + 22'(doe3);
      dn.ok  <= ok3;
    end
  end

endmodule

`default_nettype wire

>>> verif/calendar_days_between_dates_test.sv
// Self-checking testbench for the days-between-dates block: directed table, then random words.
module calendar_days_between_dates_test;
  import cbd_pkg::*;

  localparam int RANDOM_WORDS = 750;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  // One row of the directed table; want is used only where known is set
  typedef struct {
    dates_t  w;
    bit      known;
    result_t want;
  } row_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    dates_valid  = 1'b0;
  logic    dates_ready;
  dates_t  dates        = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  result_t pending[$];     // day counts and status codes still owed by the block
  result_t want_now;
  row_t    script[$];
  int      words_in    = 0;
  int      mismatches  = 0;
  int      burst_left  = 0;
  int      cycles      = 0;
  bit      holding     = 1'b0;
  bit      hold_done   = 1'b0;

  calendar_days_between_dates u_top (
    .clk          (clk),
    .rst          (rst),
    .dates_valid  (dates_valid),
    .dates_ready  (dates_ready),
    .dates        (dates),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the prediction
  // ---------------------------------------------------------------------------

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_len(int y, int m);
    case (m)
      2:             return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic bit date_valid(date_t t);
    if (t.year < 1 || t.year > YEAR_MAX) return 1'b0;
    if (t.month < 1 || t.month > MONTH_MAX) return 1'b0;
    if (t.day < 1 || t.day > month_len(t.year, t.month)) return 1'b0;
    return 1'b1;
  endfunction

  // Days since the day before 1 January of year 1, counting whole years first
  function automatic int day_index(date_t t);
    int prior;
    int total;
    prior = int'(t.year) - 1;
    total = prior * 365 + prior / 4 - prior / 100 + prior / 400;
    for (int mm = 1; mm < int'(t.month); mm++) total += month_len(t.year, mm);
    return total + int'(t.day);
  endfunction

  function automatic result_t days_between(dates_t w);
    result_t r;
    date_t   first;
    date_t   second;
    int      a;
    int      b;
    r = '0;
    {first, second} = w;
    // The first date is judged before the second; any failure zeroes the count
    if (!date_valid(first)) begin
      r.status = ST_BAD_FIRST;
    end else if (!date_valid(second)) begin
      r.status = ST_BAD_SECOND;
    end else begin
      a = day_index(first);
      b = day_index(second);
      if (b < a) begin
        r.status = ST_REVERSED;
      end else begin
        r.status    = ST_OK;
        r.day_count = CountW'(b - a);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic row_t row(int sy, int sm, int sd, int ey, int em, int ed,
                               bit known = 1'b0, int cnt = 0,
                               logic [1:0] st = ST_OK);
    row_t r;
    r.w.start_year  = YearW'(sy);
    r.w.start_month = MonthW'(sm);
    r.w.start_day   = DayW'(sd);
    r.w.end_year    = YearW'(ey);
    r.w.end_month   = MonthW'(em);
    r.w.end_day     = DayW'(ed);
    r.known          = known;
    r.want.day_count = CountW'(cnt);
    r.want.status    = st;
    return r;
  endfunction

  // Lean toward the ends of the year range and toward century and leap years
  function automatic date_t random_date();
    date_t t;
    int    y;
    int    m;
    int    len;
    case ($urandom_range(0, 7))
      0:       y = $urandom_range(1, 4);
      1:       y = $urandom_range(9996, 9999);
      2:       y = 100 * $urandom_range(1, 99);
      3:       y = 4 * $urandom_range(1, 2499);
      default: y = $urandom_range(1, 9999);
    endcase
    m   = $urandom_range(1, 12);
    len = month_len(y, m);
    t.year  = YearW'(y);
    t.month = MonthW'(m);
    case ($urandom_range(0, 3))
      0:       t.day = DayW'(len);
      1:       t.day = DayW'(1);
      default: t.day = DayW'($urandom_range(1, len));
    endcase
    return t;
  endfunction

  // Spoil one field of a valid date, or make it a day past the end of February
  function automatic date_t spoil(date_t t);
    case ($urandom_range(0, 5))
      0: t.year  = '0;
      1: t.year  = YearW'($urandom_range(10000, 16383));
      2: t.month = '0;
      3: t.month = MonthW'($urandom_range(13, 15));
      4: t.day   = '0;
      default: begin
        t.month = MonthW'(2);
        t.day   = DayW'($urandom_range(is_leap(t.year) ? 30 : 29, 31));
      end
    endcase
    return t;
  endfunction

  function automatic dates_t random_pair();
    dates_t w;
    date_t  a;
    date_t  b;
    date_t  t;
    int     pick;
    pick = $urandom_range(0, 99);
    a = random_date();
    b = random_date();
    // Keep some pairs within a year or two of each other, a few identical
    if (pick < 30) begin
      b.year = a.year + ((a.year < YEAR_MAX) ? YearW'($urandom_range(0, 1)) : '0);
      b.day  = DayW'($urandom_range(1, month_len(b.year, b.month)));
      if (pick < 5) b = a;
    end
    if (pick < 65) begin
      // Ordered pairs: the bulk of the traffic gets a real count
      if (day_index(b) < day_index(a)) begin
        t = a;
        a = b;
        b = t;
      end
      w = {a, b};
    end else if (pick < 75) begin
      w = {a, b};
    end else if (pick < 82) begin
      w = {spoil(a), b};
    end else if (pick < 88) begin
      w = {a, spoil(b)};
    end else if (pick < 90) begin
      w = {spoil(a), spoil(b)};
    end else begin
      w = dates_t'($bits(dates_t)'({$urandom, $urandom}));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one word, hold it until accepted, then maybe idle
  // ---------------------------------------------------------------------------

  task automatic offer(input dates_t w, input bit known, input result_t want);
    int gap;
    dates       <= w;
    dates_valid <= 1'b1;
    do @(posedge clk); while (!dates_ready);
    pending.push_back(known ? want : days_between(w));
    words_in++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!holding) begin
      // Drop valid for a random gap, then start a new burst; some bursts run long
      gap = $urandom_range(1, 8);
      dates_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 12);
    end
  endtask

  initial begin : sender
    dates_t w;
    script = '{
      // Equal dates at both ends of the range
      row(1, 1, 1, 1, 1, 1, 1'b1, 0, ST_OK),
      row(9999, 12, 31, 9999, 12, 31, 1'b1, 0, ST_OK),
      // Widest span and its reverse
      row(1, 1, 1, 9999, 12, 31, 1'b1, COUNT_MAX, ST_OK),
      row(9999, 12, 31, 1, 1, 1, 1'b1, 0, ST_REVERSED),
      // Bad first date: one field at a time, and one row with year and month both bad
      row(0, 1, 1, 2000, 1, 1, 1'b1, 0, ST_BAD_FIRST),
      row(16383, 15, 31, 2000, 1, 1, 1'b1, 0, ST_BAD_FIRST),
      row(2024, 0, 10, 2024, 1, 1, 1'b1, 0, ST_BAD_FIRST),
      row(2024, 13, 10, 2024, 1, 1, 1'b1, 0, ST_BAD_FIRST),
      row(2024, 4, 31, 2024, 5, 1, 1'b1, 0, ST_BAD_FIRST),
      row(2024, 5, 0, 2024, 6, 1, 1'b1, 0, ST_BAD_FIRST),
      row(1900, 2, 29, 1900, 3, 1, 1'b1, 0, ST_BAD_FIRST),
      // Both bad: the first date wins
      row(10000, 6, 15, 0, 0, 0, 1'b1, 0, ST_BAD_FIRST),
      // Bad second date
      row(2023, 1, 1, 2023, 2, 29, 1'b1, 0, ST_BAD_SECOND),
      row(2023, 1, 1, 0, 5, 5, 1'b1, 0, ST_BAD_SECOND),
      row(2023, 1, 1, 12345, 5, 5, 1'b1, 0, ST_BAD_SECOND),
      row(2023, 1, 1, 2023, 15, 1, 1'b1, 0, ST_BAD_SECOND),
      row(2023, 1, 1, 2023, 6, 31, 1'b1, 0, ST_BAD_SECOND),
      row(2023, 1, 1, 2023, 7, 0, 1'b1, 0, ST_BAD_SECOND),
      // One day backward
      row(2023, 3, 2, 2023, 3, 1, 1'b1, 0, ST_REVERSED),
      // Year and leap-day boundaries
      row(1999, 12, 31, 2000, 1, 1, 1'b1, 1, ST_OK),
      row(1900, 2, 28, 1900, 3, 1, 1'b1, 1, ST_OK),
      row(2024, 2, 28, 2024, 3, 1, 1'b1, 2, ST_OK),
      row(2000, 2, 29, 2000, 3, 1),
      row(2004, 2, 29, 2005, 2, 28),
      row(1, 3, 1, 400, 2, 29)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) offer(script[i].w, script[i].known, script[i].want);
    repeat (RANDOM_WORDS) begin
      w = random_pair();
      offer(w, 1'b0, '0);
    end
    dates_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray word
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[calendar_days_between_dates] OK");
    end else begin
      $display("[calendar_days_between_dates] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stretches of different stall patterns, plus one long hold-off
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int mode;
    int span;
    int phase;
    span  = 0;
    mode  = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && words_in >= 300) begin
        // Hold off long enough to fill the pipeline and the skid stage
        result_ready <= 1'b0;
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding   = 1'b0;
        hold_done = 1'b1;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 80);
      end
      span--;
      phase++;
      case (mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= 1'($urandom_range(0, 1));
        2:       result_ready <= (phase % 4 == 0);
        default: result_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted result word with the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending.size() == 0) begin
        $error("unexpected result word: day_count %0d status %0d",
               result.day_count, result.status);
        mismatches++;
      end else begin
        want_now = pending.pop_front();
        if (result.day_count !== want_now.day_count) begin
          $error("day_count: expected %0d, got %0d", want_now.day_count, result.day_count);
          mismatches++;
        end
        if (result.status !== want_now.status) begin
          $error("status: expected %0d, got %0d", want_now.status, result.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[calendar_days_between_dates] ERROR");
      $finish;
    end
  end

endmodule

>>> sim.f
src/cbd_pkg.sv
src/cbd_daynum.sv
src/calendar_days_between_dates.sv
verif/calendar_days_between_dates_test.sv
